>>> rtl/core/tsfu_pkg.sv
package tsfu_pkg;

  localparam int unsigned WordW  = 48;
  localparam int unsigned ArgW   = 32;
  localparam int unsigned CountW = 16;
  localparam logic [CountW-1:0] DefaultTerms = 16'd30000;

  typedef enum logic [2:0] {
    KIND_SIN  = 3'd0,
    KIND_COS  = 3'd1,
    KIND_EXP  = 3'd2,
    KIND_LOG1 = 3'd3,
    KIND_LOGZ = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_OVERFLOW = 2'd1,
    STATUS_DIV_ZERO = 2'd2
  } status_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE, ST_W_DIV, ST_W_FRAC, ST_MUL_SQ, ST_ADD, ST_NEXT,
    ST_T_MUL, ST_T_NMUL, ST_T_DIV, ST_FINISH
  } state_e;

  // serial multiply request and reply between sequencer and multiplier
  typedef struct packed {
    logic             start;
    logic [WordW-1:0] a_mag;
    logic [WordW-1:0] b_mag;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic [WordW:0]     prod;
    logic               ovf;
    logic [2*WordW-1:0] full;
  } mul_rsp_t;

  // serial divide: num / den, quotient truncated
  typedef struct packed {
    logic             start;
    logic [95:0]      num;
    logic [WordW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [95:0]      quo;
  } div_rsp_t;

endpackage

>>> rtl/core/tsfu_mul.sv
// shift-add multiplier, one bit of b per cycle; result is (a*b) >> FracBits,
// clamped to 2^48 with an overflow flag; the full product is also given
module tsfu_mul #(
  parameter int unsigned FracBits = 28
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tsfu_pkg::mul_req_t req_i,
  output tsfu_pkg::mul_rsp_t rsp_o
);
  import tsfu_pkg::*;

  localparam int unsigned CntW = $clog2(WordW + 1);
  localparam logic [2*WordW-1:0] Lim = {{(WordW-1){1'b0}}, 1'b1, {WordW{1'b0}}};

  logic              busy_q, busy_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [2*WordW-1:0] acc_q, acc_d;
  logic [2*WordW-1:0] a_q, a_d;
  logic [WordW-1:0]  b_q, b_d;
  logic              done_q, done_d;
  logic [2*WordW-1:0] shifted;

  // final scaling of the full product
  assign shifted = acc_q >> FracBits;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      acc_d  = '0;
      a_d    = {{WordW{1'b0}}, req_i.a_mag};
      b_d    = req_i.b_mag;
    end else if (busy_q) begin
      if (b_q[0]) acc_d = acc_q + a_q;
      a_d   = a_q << 1;
      b_d   = b_q >> 1;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(WordW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.ovf  = (shifted > Lim);
  assign rsp_o.prod = (shifted > Lim) ? Lim[WordW:0] : shifted[WordW:0];
  assign rsp_o.full = acc_q;

endmodule

>>> rtl/core/tsfu_div.sv
// restoring divider, one quotient bit per cycle, msb first
module tsfu_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tsfu_pkg::div_req_t req_i,
  output tsfu_pkg::div_rsp_t rsp_o
);
  import tsfu_pkg::*;

  localparam int unsigned NumW = 96;
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic              busy_q, busy_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [NumW-1:0]   num_q, num_d;
  logic [WordW:0]    rem_q, rem_d;
  logic [WordW-1:0]  den_q, den_d;
  logic              done_q, done_d;
  logic [WordW:0]    trial;

  assign trial = {rem_q[WordW-1:0], num_q[NumW-1]};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
    end else if (busy_q) begin
      // shift in one numerator bit, subtract when it fits
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        num_d = {num_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        num_d = {num_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(NumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = num_q;

endmodule

>>> rtl/core/taylor_series_function_unit.sv
// sequence: n terms are summed before the strobe; setup squares x for sin and cos, and for
// log z divides first and then squares w, with no setup otherwise; log(1+x) and log z add
// an extra multiply by the numerator factor to each term; the series stops after the first
// zero term
// throughput: one item at a time, busy is high until the strobe cycle ends; the receiver
// cannot stall. reset clears control state and sets terms_q to 30000
module taylor_series_function_unit #(
  parameter int unsigned FracBits = 28
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind_i,
  input  logic signed [31:0] argument_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  output logic        done_o,
  output logic signed [47:0] series_sum_o,
  output logic [1:0]  status_o
);
  import tsfu_pkg::*;

  localparam logic [WordW-1:0] MagLim = {1'b1, {(WordW-1){1'b0}}};
  localparam logic [WordW:0] One = (WordW+1)'(1) << FracBits;

  state_e state_q, state_d;
  logic [CountW-1:0] terms_q;
  logic [2:0]  kind_q, kind_d;
  logic        ovf_q, ovf_d;
  logic        tneg_q, tneg_d;       // sign of current term
  logic [WordW-1:0] tmag_q, tmag_d;  // magnitude of current term
  logic        mneg_q, mneg_d;
  logic [WordW-1:0] mmag_q, mmag_d;  // per-term multiplier
  logic signed [WordW+1:0] acc_q, acc_d;
  logic [CountW-1:0] j_q, j_d;
  logic        pneg_q, pneg_d;       // sign of product in flight
  logic [WordW:0] pmag_q, pmag_d;
  logic        done_q, done_d;
  logic signed [WordW-1:0] sum_q, sum_d;
  logic [1:0]  stat_q, stat_d;

  mul_req_t mreq;
  mul_rsp_t mrsp;
  div_req_t dreq;
  div_rsp_t drsp;

  tsfu_mul #(.FracBits(FracBits)) u_mul (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(mreq), .rsp_o(mrsp));
  tsfu_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  // argument helpers
  logic signed [WordW:0] x_ext, num_s, den_s;
  logic [WordW:0] num_m, den_m;
  assign x_ext = (WordW+1)'(argument_i);
  assign num_s = $signed(One) - x_ext;
  assign den_s = $signed(One) + x_ext;
  assign num_m = num_s[WordW] ? -num_s : num_s;
  assign den_m = den_s[WordW] ? -den_s : den_s;

  // numerator and denominator of the term recurrence
  logic [35:0] nfac, dfac;
  logic [CountW:0] jj;
  assign jj = {j_q, 1'b0};
  always_comb begin
    nfac = 36'd1;
    dfac = 36'd1;
    case (kind_q)
      KIND_SIN:  dfac = 36'(jj) * 36'(jj + 1'b1);
      KIND_COS:  dfac = 36'(jj) * 36'(jj - 1'b1);
      KIND_EXP:  dfac = 36'(j_q);
      KIND_LOG1: begin nfac = 36'(j_q); dfac = 36'(j_q) + 36'd1; end
      default:   begin nfac = 36'(jj) - 36'd1; dfac = 36'(jj) + 36'd1; end
    endcase
  end

  // clamp of a product magnitude for a given sign
  function automatic logic [WordW:0] lim_of(input logic neg);
    lim_of = neg ? {1'b0, MagLim} : {1'b0, MagLim - 1'b1};
  endfunction

  logic signed [WordW+1:0] term_s;
  logic [WordW+1:0] acc_abs;
  assign term_s  = tneg_q ? -$signed({2'b0, tmag_q}) : $signed({2'b0, tmag_q});
  assign acc_abs = acc_q[WordW+1] ? -acc_q : acc_q;

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    ovf_d   = ovf_q;
    tneg_d  = tneg_q;
    tmag_d  = tmag_q;
    mneg_d  = mneg_q;
    mmag_d  = mmag_q;
    acc_d   = acc_q;
    j_d     = j_q;
    pneg_d  = pneg_q;
    pmag_d  = pmag_q;
    done_d  = 1'b0;
    sum_d   = sum_q;
    stat_d  = stat_q;
    mreq    = '0;
    dreq    = '0;
    case (state_q)
      ST_IDLE: begin
        if (start && !busy) begin
          kind_d = kind_i;
          ovf_d  = 1'b0;
          acc_d  = '0;
          j_d    = '0;
          if (kind_i > KIND_LOGZ) begin
            sum_d = '0; stat_d = STATUS_OK; done_d = 1'b1;
          end else if (kind_i == KIND_LOGZ) begin
            if (den_s == '0) begin
              sum_d = '0; stat_d = STATUS_DIV_ZERO; done_d = 1'b1;
            end else begin
              tneg_d = num_s[WordW] ^ den_s[WordW];
              dreq.start = 1'b1;
              dreq.num   = 96'(num_m) << FracBits;
              dreq.den   = den_m[WordW-1:0];
              state_d    = ST_W_DIV;
            end
          end else begin
            tneg_d = argument_i[ArgW-1];
            tmag_d = argument_i[ArgW-1] ? WordW'(-x_ext) : WordW'(x_ext);
            mneg_d = tneg_d;
            mmag_d = tmag_d;
            if (kind_i == KIND_COS || kind_i == KIND_EXP) begin
              tneg_d = 1'b0; tmag_d = One[WordW-1:0];
            end
            if (kind_i == KIND_SIN || kind_i == KIND_COS) begin
              mreq.start = 1'b1;
              mreq.a_mag = argument_i[ArgW-1] ? WordW'(-x_ext) : WordW'(x_ext);
              mreq.b_mag = mreq.a_mag;
              state_d = ST_MUL_SQ;
            end else begin
              state_d = ST_ADD;
            end
          end
        end
      end
      ST_W_DIV: begin
        if (drsp.done) begin
          tmag_d = (drsp.quo > 96'(lim_of(tneg_q))) ? WordW'(lim_of(tneg_q))
                                                    : drsp.quo[WordW-1:0];
          if (drsp.quo > 96'(lim_of(tneg_q))) ovf_d = 1'b1;
          state_d = ST_W_FRAC;
        end
      end
      ST_W_FRAC: begin
        mreq.start = 1'b1;
        mreq.a_mag = tmag_q;
        mreq.b_mag = tmag_q;
        state_d = ST_MUL_SQ;
      end
      ST_MUL_SQ: begin
        if (mrsp.done) begin
          mneg_d = 1'b0;
          mmag_d = (mrsp.prod > lim_of(1'b0)) ? WordW'(lim_of(1'b0))
                                               : mrsp.prod[WordW-1:0];
          if (mrsp.ovf || mrsp.prod > lim_of(1'b0)) ovf_d = 1'b1;
          state_d = ST_ADD;
        end
      end
      // accumulate term j, saturating
      ST_ADD: begin
        if (j_q == terms_q) begin
          state_d = ST_FINISH;
        end else begin
          acc_d = acc_q + term_s;
          if (acc_d > $signed({2'b0, MagLim - 1'b1})) begin
            acc_d = $signed({2'b0, MagLim - 1'b1}); ovf_d = 1'b1;
          end else if (acc_d < -$signed({2'b0, MagLim})) begin
            acc_d = -$signed({2'b0, MagLim}); ovf_d = 1'b1;
          end
          j_d = j_q + 1'b1;
          state_d = (tmag_q == '0) ? ST_FINISH : ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (j_q == terms_q) begin
          state_d = ST_FINISH;
        end else begin
          mreq.start = 1'b1;
          mreq.a_mag = tmag_q;
          mreq.b_mag = mmag_q;
          pneg_d = tneg_q ^ mneg_q ^
                   (kind_q == KIND_SIN || kind_q == KIND_COS || kind_q == KIND_LOG1);
          state_d = ST_T_MUL;
        end
      end
      ST_T_MUL: begin
        if (mrsp.done) begin
          if (mrsp.ovf || mrsp.prod > lim_of(pneg_q)) ovf_d = 1'b1;
          pmag_d = (mrsp.prod > lim_of(pneg_q)) ? lim_of(pneg_q) : mrsp.prod;
          if (kind_q == KIND_LOG1 || kind_q == KIND_LOGZ) begin
            // scale by the numerator factor on the serial multiplier
            mreq.start = 1'b1;
            mreq.a_mag = pmag_d[WordW-1:0];
            mreq.b_mag = WordW'(nfac);
            state_d = ST_T_NMUL;
          end else begin
            dreq.start = 1'b1;
            dreq.num   = 96'(pmag_d);
            dreq.den   = WordW'(dfac);
            state_d = ST_T_DIV;
          end
        end
      end
      ST_T_NMUL: begin
        if (mrsp.done) begin
          dreq.start = 1'b1;
          dreq.num   = mrsp.full;
          dreq.den   = WordW'(dfac);
          state_d = ST_T_DIV;
        end
      end
      ST_T_DIV: begin
        if (drsp.done) begin
          tneg_d = pneg_q;
          if (drsp.quo > 96'(lim_of(pneg_q))) begin
            ovf_d = 1'b1; tmag_d = WordW'(lim_of(pneg_q));
          end else begin
            tmag_d = drsp.quo[WordW-1:0];
          end
          state_d = ST_ADD;
        end
      end
      ST_FINISH: begin
        if (kind_q == KIND_LOGZ) begin
          // -2 * acc, saturated
          if (acc_q > 0) begin
            if ((acc_abs << 1) > {2'b0, MagLim}) begin
              sum_d = $signed(MagLim); ovf_d = 1'b1;
            end else sum_d = WordW'(-(acc_q <<< 1));
          end else begin
            if ((acc_abs << 1) > {2'b0, MagLim - 1'b1}) begin
              sum_d = $signed(MagLim - 1'b1); ovf_d = 1'b1;
            end else sum_d = WordW'(acc_abs << 1);
          end
        end else begin
          sum_d = acc_q[WordW-1:0];
        end
        stat_d  = ovf_d ? STATUS_OVERFLOW : STATUS_OK;
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      terms_q <= DefaultTerms;
      done_q  <= 1'b0;
      j_q     <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      j_q     <= j_d;
      ovf_q   <= ovf_d;
      if (cfg_we_i) terms_q <= cfg_data_i;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    tneg_q <= tneg_d;
    tmag_q <= tmag_d;
    mneg_q <= mneg_d;
    mmag_q <= mmag_d;
    acc_q  <= acc_d;
    pneg_q <= pneg_d;
    pmag_q <= pmag_d;
    sum_q  <= sum_d;
    stat_q <= stat_d;
  end

  assign busy         = (state_q != ST_IDLE) || done_q;
  assign done_o       = done_q;
  assign series_sum_o = sum_q;
  assign status_o     = stat_q;

endmodule
